/* hw/rtl/gkg_pkg.sv */
// ---------------------------------------------------------------------------
// gkg_pkg
// Shared constants and exp tables for the Gaussian kernel generator.
// ---------------------------------------------------------------------------
package gkg_pkg;

   localparam int MAX_TAPS_DEF = 64;

   localparam logic [6:0]  DIAMETER_RST   = 7'd5;
   localparam logic [4:0]  PIX_RADIUS_RST = 5'd2;
   localparam logic [12:0] FRAC_RADIUS_RST = 13'd512;
   localparam logic [15:0] SIGMA_RST      = 16'd4096;

   localparam logic [1:0] REG_DIAMETER    = 2'd0;
   localparam logic [1:0] REG_PIX_RADIUS  = 2'd1;
   localparam logic [1:0] REG_FRAC_RADIUS = 2'd2;
   localparam logic [1:0] REG_SIGMA       = 2'd3;

   // exp(-n) for integer part n, Q1.16 with 1.0 = 65536
   function automatic logic [16:0] exp_int(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0: v = 17'd65536;  4'd1: v = 17'd24109; 4'd2: v = 17'd8869;
         4'd3: v = 17'd3263;   4'd4: v = 17'd1200;  4'd5: v = 17'd442;
         4'd6: v = 17'd162;    4'd7: v = 17'd60;    4'd8: v = 17'd22;
         4'd9: v = 17'd8;      4'd10: v = 17'd3;    4'd11: v = 17'd1;
         default: v = 17'd0;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] exp_hi(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0: v = 17'd65536;  4'd1: v = 17'd61565;  4'd2: v = 17'd57835;
         4'd3: v = 17'd54331;  4'd4: v = 17'd51039;  4'd5: v = 17'd47947;
         4'd6: v = 17'd45042;  4'd7: v = 17'd42313;  4'd8: v = 17'd39750;
         4'd9: v = 17'd37341;  4'd10: v = 17'd35079; 4'd11: v = 17'd32954;
         4'd12: v = 17'd30957; 4'd13: v = 17'd29081; 4'd14: v = 17'd27319;
         default: v = 17'd25664;
      endcase
      return v;
   endfunction

   function automatic logic [16:0] exp_lo(input logic [3:0] idx);
      logic [16:0] v;
      case (idx)
         4'd0: v = 17'd65536;  4'd1: v = 17'd65280;  4'd2: v = 17'd65026;
         4'd3: v = 17'd64772;  4'd4: v = 17'd64520;  4'd5: v = 17'd64268;
         4'd6: v = 17'd64018;  4'd7: v = 17'd63768;  4'd8: v = 17'd63520;
         4'd9: v = 17'd63272;  4'd10: v = 17'd63025; 4'd11: v = 17'd62780;
         4'd12: v = 17'd62535; 4'd13: v = 17'd62291; 4'd14: v = 17'd62048;
         default: v = 17'd61806;
      endcase
      return v;
   endfunction

endpackage

/* hw/rtl/gaussian_kernel_generator.sv */
// ---------------------------------------------------------------------------
// gaussian_kernel_generator
// Normalized 1-D Gaussian kernel generator with APB-style register port.
// ---------------------------------------------------------------------------
// A start beat with generate_req set builds a kernel of diameter taps and
// emits them one per rsp_valid strobe, tap 0 first, rsp_last on the final
// tap; busy stays high until then and the receiver cannot stall. Every
// active off-center tap takes one 63-step serial divide for the exponent
// plus table multiplies, and every emitted tap another divide (the same
// divider normalizes against the weight sum), so the shared serial
// divider sets the pace of kernel generation.
module gaussian_kernel_generator
   import gkg_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_generate_req,
   output logic        rsp_valid,
   output logic [5:0]  rsp_tap_index,
   output logic [15:0] rsp_coefficient,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   logic [6:0]  diameter_ff;
   logic [4:0]  pix_radius_ff;
   logic [12:0] frac_radius_ff;
   logic [15:0] sigma_ff;
   logic        wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         diameter_ff    <= DIAMETER_RST;
         pix_radius_ff  <= PIX_RADIUS_RST;
         frac_radius_ff <= FRAC_RADIUS_RST;
         sigma_ff       <= SIGMA_RST;
      end else if (wr) begin
         case (paddr[3:2])
            REG_DIAMETER:    diameter_ff    <= pwdata[6:0];
            REG_PIX_RADIUS:  pix_radius_ff  <= pwdata[4:0];
            REG_FRAC_RADIUS: frac_radius_ff <= pwdata[12:0];
            REG_SIGMA:       sigma_ff       <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_DIAMETER:    prdata = {25'd0, diameter_ff};
         REG_PIX_RADIUS:  prdata = {27'd0, pix_radius_ff};
         REG_FRAC_RADIUS: prdata = {19'd0, frac_radius_ff};
         REG_SIGMA:       prdata = {16'd0, sigma_ff};
         default:         prdata = '0;
      endcase
   end

   gkg_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
      .clock(clock), .reset(reset), .start(start && !busy),
      .req_generate_req(req_generate_req),
      .diameter(diameter_ff), .pix_radius(pix_radius_ff),
      .frac_radius(frac_radius_ff), .sigma(sigma_ff),
      .busy(busy), .rsp_valid(rsp_valid), .rsp_tap_index(rsp_tap_index),
      .rsp_coefficient(rsp_coefficient), .rsp_last(rsp_last)
   );

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid) else $error("last without valid");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy) else $error("busy after last tap");
   a_no_valid_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy) else $error("tap outside kernel");
endmodule

/* hw/rtl/gkg_ram.sv */
// ---------------------------------------------------------------------------
// gkg_ram
// Generic single-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module gkg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* hw/rtl/gkg_div.sv */
// ---------------------------------------------------------------------------
// gkg_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module gkg_div #(
   parameter int NW = 64,
   parameter int DW = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW+1:0] trial;

   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, q_ff[NW-1]};
      if (start) begin
         q_in = num; rem_in = '0; den_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift one numerator bit into the remainder, subtract if it fits
         if (trial >= {2'b0, den_ff}) begin
            rem_in = (DW+1)'(trial - {2'b0, den_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DW:0];
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* hw/rtl/gkg_ctrl.sv */
// ---------------------------------------------------------------------------
// gkg_ctrl
// Sequencer: raw weight pass into the tap store, then normalize pass out.
// ---------------------------------------------------------------------------
module gkg_ctrl
   import gkg_pkg::*;
#(
   parameter int MAX_TAPS = MAX_TAPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_generate_req,
   input  logic [6:0]  diameter,
   input  logic [4:0]  pix_radius,
   input  logic [12:0] frac_radius,
   input  logic [15:0] sigma,
   output logic        busy,
   output logic        rsp_valid,
   output logic [5:0]  rsp_tap_index,
   output logic [15:0] rsp_coefficient,
   output logic        rsp_last
);
   localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SETUP, ST_TAP, ST_EXP, ST_MUL1, ST_MUL2, ST_WRITE,
      ST_READ, ST_RWAIT, ST_DIV, ST_OUT
   } state_type;

   state_type   state_ff;
   logic [6:0]  dcount_ff, k_ff, start_ff, stop_ff;
   logic [4:0]  r_ff;
   logic [39:0] sum_ff;
   logic [5:0]  dabs_ff;
   logic [16:0] w_ff;
   logic [32:0] p_ff;
   logic [5:0]  idx_ff;
   logic [15:0] coef_ff;
   logic        valid_ff, last_ff;
   logic        div_go_ff;

   // exponent divider: d^2 * 2^51 / (R^2 S^2)
   logic [25:0] rr, rr_ff;
   logic [31:0] ss, ss_ff;
   logic [57:0] rrss_ff;
   logic        dstart;
   logic [62:0] dnum;
   logic [63:0] dden;
   logic        ddone;
   logic [62:0] dquot;

   // common divider serves both passes with a 64-bit denominator
   gkg_div #(.NW(63), .DW(64)) u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .done(ddone), .quot(dquot)
   );

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0]   ram_rd;

   gkg_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_store (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr), .wr_data({15'd0, w_ff}),
      .rd_data(ram_rd)
   );

   logic [6:0] dsat, rsel, rmax, pos;
   logic [5:0] dabs_c;
   logic       active;

   always_comb begin
      dsat = (diameter == 7'd0) ? 7'd1 : diameter;
      if (dsat > 7'(MAX_TAPS)) dsat = 7'(MAX_TAPS);
      rsel = (pix_radius == 5'd0) ? 7'd1 : {2'b0, pix_radius};
      rmax = (dsat - 7'd1) >> 1;
      if (rsel > rmax) rsel = rmax;
      pos    = k_ff - start_ff;
      active = (k_ff >= start_ff) && (k_ff < stop_ff);
      dabs_c = (pos >= {2'b0, r_ff}) ? 6'(pos - {2'b0, r_ff})
                                     : 6'({2'b0, r_ff} - pos);
      rr = 26'(frac_radius) * 26'(frac_radius);
      ss = 32'(sigma) * 32'(sigma);
   end

   assign ram_addr = AW'(k_ff);
   assign ram_we   = (state_ff == ST_WRITE);
   assign dstart   = div_go_ff;
   assign dnum     = (state_ff == ST_DIV) ? 63'(({ram_rd, 16'd0}) + 48'(sum_ff >> 1))
                                          : {12'(dabs_ff) * 12'(dabs_ff), 51'd0};
   assign dden     = (state_ff == ST_DIV) ? {24'd0, sum_ff} : {6'd0, rrss_ff};

   logic [16:0] p1_r;
   assign p1_r = 17'((p_ff + 33'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         div_go_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff  <= (state_ff == ST_OUT);
         div_go_ff <= ((state_ff == ST_TAP) && active && (dabs_c != 6'd0) &&
                       (frac_radius != 13'd0) && (sigma != 16'd0)) ||
                      ((state_ff == ST_RWAIT) && (sum_ff != 40'd0));
         case (state_ff)
            ST_IDLE: begin
               if (start && req_generate_req) begin
                  state_ff <= ST_SETUP;
               end
            end
            ST_SETUP: begin
               dcount_ff <= dsat;
               r_ff      <= 5'(rsel);
               start_ff  <= (dsat - (rsel << 1) - 7'd1) >> 1;
               stop_ff   <= dsat - ((dsat - (rsel << 1) - 7'd1) >> 1);
               rr_ff     <= rr;
               ss_ff     <= ss;
               k_ff      <= '0;
               sum_ff    <= '0;
               state_ff  <= ST_TAP;
            end
            ST_TAP: begin
               dabs_ff <= dabs_c;
               rrss_ff <= 58'(rr_ff) * 58'(ss_ff);
               if (!active) begin
                  w_ff <= '0; state_ff <= ST_WRITE;
               end else if (dabs_c == 6'd0) begin
                  w_ff <= 17'd65536; state_ff <= ST_WRITE;
               end else if (frac_radius == 13'd0 || sigma == 16'd0) begin
                  w_ff <= '0; state_ff <= ST_WRITE;
               end else begin
                  state_ff <= ST_EXP;
               end
            end
            ST_EXP: begin
               if (ddone) begin
                  if (dquot >= 63'd3328) begin
                     w_ff <= '0; state_ff <= ST_WRITE;
                  end else begin
                     p_ff <= 33'(exp_int(dquot[11:8])) * 33'(exp_hi(dquot[7:4]));
                     w_ff <= exp_lo(dquot[3:0]);
                     state_ff <= ST_MUL1;
                  end
               end
            end
            ST_MUL1: begin
               p_ff <= 33'(p1_r) * 33'(w_ff);
               state_ff <= ST_MUL2;
            end
            ST_MUL2: begin
               w_ff <= p1_r; state_ff <= ST_WRITE;
            end
            ST_WRITE: begin
               sum_ff <= sum_ff + 40'(w_ff);
               if (k_ff == dcount_ff - 7'd1) begin
                  k_ff <= '0; state_ff <= ST_READ;
               end else begin
                  k_ff <= k_ff + 7'd1; state_ff <= ST_TAP;
               end
            end
            ST_READ: state_ff <= ST_RWAIT;
            ST_RWAIT: begin
               if (sum_ff == 40'd0) begin
                  coef_ff <= '0; state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (ddone) begin
                  coef_ff  <= (dquot > 63'd65535) ? 16'hFFFF : dquot[15:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // emit one beat
               idx_ff   <= k_ff[5:0];
               last_ff  <= (k_ff == dcount_ff - 7'd1);
               if (k_ff == dcount_ff - 7'd1) begin
                  state_ff <= ST_IDLE;
               end else begin
                  k_ff <= k_ff + 7'd1; state_ff <= ST_READ;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_tap_index   = idx_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_last        = valid_ff && last_ff;
endmodule
